// File: src/lisg_pkg.sv
// ----------------------------------------------------------------------------
// lisg_pkg
// Shared constants, types and helpers for the log image Sobel gradient block.
// ----------------------------------------------------------------------------
package lisg_pkg;

   localparam int MAX_WIDTH   = 1024;
   localparam int HEIGHT_CAP  = 1024;
   localparam int LOG_BITS    = 20;
   localparam int IN_BITS     = 20;
   localparam int PIX_W       = 8;
   localparam int TABLE_DEPTH = 2 ** PIX_W;
   localparam int GRAD_W      = 24;
   localparam int CFG_W       = 11;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 3;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(HEIGHT_CAP);
   localparam int DIM_A       = (CFG_W > COL_W + 1) ? CFG_W : COL_W + 1;
   localparam int DIM_W       = (DIM_A > ROW_W + 1) ? DIM_A : ROW_W + 1;
   localparam int SUM_W       = LOG_BITS + 3;
   localparam int SAT_W       = (SUM_W > GRAD_W) ? SUM_W : GRAD_W;
   localparam int NUM_RES     = 4;

   // input item kinds
   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_TABLE = 1'b1;

   // register index (taken from paddr bit 2)
   localparam logic REG_IMAGE_WIDTH  = 1'b0;
   localparam logic REG_IMAGE_HEIGHT = 1'b1;

   // result kinds, in emission order
   localparam int RES_INNER  = 0;
   localparam int RES_RIGHT  = 1;
   localparam int RES_BOTTOM = 2;
   localparam int RES_CORNER = 3;

   localparam logic signed [SAT_W-1:0] GRAD_MAX = SAT_W'(2 ** (GRAD_W - 1) - 1);
   localparam logic signed [SAT_W-1:0] GRAD_MIN = SAT_W'(-(2 ** (GRAD_W - 1)));

   typedef logic signed [LOG_BITS-1:0] log_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [GRAD_W-1:0]   grad_type;
   typedef logic [CFG_W-1:0]           dim_cfg_type;

   typedef struct packed {
      logic [NUM_RES-1:0] mask;
      logic               top_refl;
      logic               left_refl;
   } res_info_type;

   typedef struct packed {
      res_info_type info;
      log_type      lv;
      log_type      top;
      log_type      mid;
   } pix_data_type;

   function automatic grad_type sat_grad(input sum_type v);
      logic signed [SAT_W-1:0] x;
      grad_type                res;
      x = SAT_W'(v);
      if (x > GRAD_MAX) begin
         res = GRAD_MAX[GRAD_W-1:0];
      end else if (x < GRAD_MIN) begin
         res = GRAD_MIN[GRAD_W-1:0];
      end else begin
         res = x[GRAD_W-1:0];
      end
      return res;
   endfunction

endpackage

// File: src/lisg_ingress.sv
// ----------------------------------------------------------------------------
// lisg_ingress
// Frame position counters, log table and two-line store. Looks up each pixel
// and its column above, holding the result in one stage for the window.
// ----------------------------------------------------------------------------
module lisg_ingress (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [lisg_pkg::PIX_W-1:0] req_pixel,
   input  logic signed [lisg_pkg::IN_BITS-1:0] req_table_value,
   input  lisg_pkg::dim_cfg_type      image_width,
   input  lisg_pkg::dim_cfg_type      image_height,
   output logic                       pix_valid,
   output lisg_pkg::pix_data_type     pix_data,
   input  logic                       pix_take
);

   logic [lisg_pkg::COL_W-1:0] col_ff, col_in;
   logic [lisg_pkg::ROW_W-1:0] row_ff, row_in;
   logic [lisg_pkg::COL_W-1:0] cur_col;
   logic [lisg_pkg::ROW_W-1:0] cur_row;
   logic [lisg_pkg::DIM_W-1:0] w_eff, h_eff;
   logic                       restart, last_col, last_row;
   logic                       pix_acc, tbl_acc;

   lisg_pkg::log_type            log_table_ff [lisg_pkg::TABLE_DEPTH];
   logic [2*lisg_pkg::LOG_BITS-1:0] line_store_ff [lisg_pkg::MAX_WIDTH];
   lisg_pkg::log_type            tbl_q_ff;
   logic [2*lisg_pkg::LOG_BITS-1:0] line_q_ff;
   logic [2*lisg_pkg::LOG_BITS-1:0] line_wdata;

   logic                       s1_valid_ff, s1_valid_in;
   logic [lisg_pkg::COL_W-1:0] s1_col_ff;
   logic                       s1_parity_ff;
   lisg_pkg::res_info_type     s1_info_ff, s1_info_in;

   lisg_pkg::log_type line_lo, line_hi;

   assign req_ready = !s1_valid_ff || pix_take;
   assign pix_acc   = req_valid && req_ready && (req_op == lisg_pkg::OP_PIXEL);
   assign tbl_acc   = req_valid && req_ready && (req_op == lisg_pkg::OP_TABLE);

   always_comb begin
      w_eff = lisg_pkg::DIM_W'(image_width);
      if (w_eff < lisg_pkg::DIM_W'(2)) w_eff = lisg_pkg::DIM_W'(2);
      if (w_eff > lisg_pkg::DIM_W'(lisg_pkg::MAX_WIDTH)) w_eff = lisg_pkg::DIM_W'(lisg_pkg::MAX_WIDTH);
      h_eff = lisg_pkg::DIM_W'(image_height);
      if (h_eff < lisg_pkg::DIM_W'(2)) h_eff = lisg_pkg::DIM_W'(2);
      if (h_eff > lisg_pkg::DIM_W'(lisg_pkg::HEIGHT_CAP)) h_eff = lisg_pkg::DIM_W'(lisg_pkg::HEIGHT_CAP);

      // size changed under a running frame: start over at the origin
      restart = (lisg_pkg::DIM_W'(col_ff) >= w_eff) || (lisg_pkg::DIM_W'(row_ff) >= h_eff);
      cur_col = restart ? '0 : col_ff;
      cur_row = restart ? '0 : row_ff;

      last_col = (lisg_pkg::DIM_W'(cur_col) == w_eff - lisg_pkg::DIM_W'(1));
      last_row = (lisg_pkg::DIM_W'(cur_row) == h_eff - lisg_pkg::DIM_W'(1));

      col_in = col_ff;
      row_in = row_ff;
      if (pix_acc) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : cur_row + lisg_pkg::ROW_W'(1);
         end else begin
            col_in = cur_col + lisg_pkg::COL_W'(1);
            row_in = cur_row;
         end
      end

      s1_info_in.mask[lisg_pkg::RES_INNER]  = (cur_row != '0) && (cur_col != '0);
      s1_info_in.mask[lisg_pkg::RES_RIGHT]  = (cur_row != '0) && last_col;
      s1_info_in.mask[lisg_pkg::RES_BOTTOM] = last_row && (cur_col != '0);
      s1_info_in.mask[lisg_pkg::RES_CORNER] = last_row && last_col;
      s1_info_in.top_refl  = (cur_row == lisg_pkg::ROW_W'(1));
      s1_info_in.left_refl = (cur_col == lisg_pkg::COL_W'(1));

      s1_valid_in = s1_valid_ff;
      if (pix_take) s1_valid_in = 1'b0;
      if (pix_acc)  s1_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_acc) begin
         s1_col_ff    <= cur_col;
         s1_parity_ff <= cur_row[0];
         s1_info_ff   <= s1_info_in;
      end
   end

   // log table: written by table items, read once per pixel
   always_ff @(posedge clock) begin
      if (tbl_acc) log_table_ff[req_pixel] <= lisg_pkg::log_type'(req_table_value);
      if (pix_acc) tbl_q_ff <= log_table_ff[req_pixel];
   end

   // both stored rows of one column share a word; the older row gets overwritten
   assign line_lo = line_q_ff[lisg_pkg::LOG_BITS-1:0];
   assign line_hi = line_q_ff[2*lisg_pkg::LOG_BITS-1:lisg_pkg::LOG_BITS];
   assign line_wdata = s1_parity_ff ? {tbl_q_ff, line_lo} : {line_hi, tbl_q_ff};

   always_ff @(posedge clock) begin
      if (s1_valid_ff && pix_take) line_store_ff[s1_col_ff] <= line_wdata;
      if (pix_acc) line_q_ff <= line_store_ff[cur_col];
   end

   assign pix_valid     = s1_valid_ff;
   assign pix_data.info = s1_info_ff;
   assign pix_data.lv   = tbl_q_ff;
   assign pix_data.top  = s1_parity_ff ? line_hi : line_lo;
   assign pix_data.mid  = s1_parity_ff ? line_lo : line_hi;

endmodule

// File: src/lisg_emit.sv
// ----------------------------------------------------------------------------
// lisg_emit
// 3x3 window, Sobel kernels with reflected borders and the result register.
// Sends up to four results per pixel, one per cycle unless rsp_ready holds the result register.
// ----------------------------------------------------------------------------
module lisg_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pix_valid,
   input  lisg_pkg::pix_data_type pix_data,
   output logic                   pix_take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output lisg_pkg::grad_type     rsp_grad_x,
   output lisg_pkg::grad_type     rsp_grad_y,
   output logic                   rsp_frame_end
);

   // [column][row], index 2 is the newest
   lisg_pkg::log_type window_ff [3][3];

   logic [lisg_pkg::NUM_RES-1:0] mask_ff, mask_in;
   logic [lisg_pkg::NUM_RES-1:0] sel;
   logic                         top_refl_ff, left_refl_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   lisg_pkg::grad_type           rsp_grad_x_ff, rsp_grad_y_ff;
   logic                         rsp_frame_end_ff;

   logic       issue, last_pending, flush_rows, flush_cols;
   logic [1:0] rt_i, rm_i, rb_i, cl_i, cc_i, cr_i;
   lisg_pkg::sum_type lt, lm, lb, rt, rm, rb, ct, cb;
   lisg_pkg::sum_type gx, gy;

   assign issue        = (mask_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign last_pending = (mask_ff & (mask_ff - lisg_pkg::NUM_RES'(1))) == '0;
   assign pix_take     = pix_valid && ((mask_ff == '0) || (issue && last_pending));
   assign sel          = mask_ff & (~mask_ff + lisg_pkg::NUM_RES'(1));

   always_comb begin
      flush_rows = sel[lisg_pkg::RES_BOTTOM] || sel[lisg_pkg::RES_CORNER];
      flush_cols = sel[lisg_pkg::RES_RIGHT] || sel[lisg_pkg::RES_CORNER];

      // reflect-101 at the borders
      rt_i = flush_rows ? 2'd1 : (top_refl_ff ? 2'd2 : 2'd0);
      rm_i = flush_rows ? 2'd2 : 2'd1;
      rb_i = flush_rows ? 2'd1 : 2'd2;
      cl_i = flush_cols ? 2'd1 : (left_refl_ff ? 2'd2 : 2'd0);
      cc_i = flush_cols ? 2'd2 : 2'd1;
      cr_i = flush_cols ? 2'd1 : 2'd2;

      lt = lisg_pkg::SUM_W'(window_ff[cl_i][rt_i]);
      lm = lisg_pkg::SUM_W'(window_ff[cl_i][rm_i]);
      lb = lisg_pkg::SUM_W'(window_ff[cl_i][rb_i]);
      rt = lisg_pkg::SUM_W'(window_ff[cr_i][rt_i]);
      rm = lisg_pkg::SUM_W'(window_ff[cr_i][rm_i]);
      rb = lisg_pkg::SUM_W'(window_ff[cr_i][rb_i]);
      ct = lisg_pkg::SUM_W'(window_ff[cc_i][rt_i]);
      cb = lisg_pkg::SUM_W'(window_ff[cc_i][rb_i]);

      gx = (rt - lt) + ((rm - lm) <<< 1) + (rb - lb);
      gy = (lb - lt) + ((cb - ct) <<< 1) + (rb - rt);

      mask_in = mask_ff;
      if (issue)    mask_in = mask_ff & ~sel;
      if (pix_take) mask_in = pix_data.info.mask;

      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (issue)     rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_take) begin
         for (int j = 0; j < 3; j++) begin
            window_ff[0][j] <= window_ff[1][j];
            window_ff[1][j] <= window_ff[2][j];
         end
         window_ff[2][0] <= pix_data.top;
         window_ff[2][1] <= pix_data.mid;
         window_ff[2][2] <= pix_data.lv;
         top_refl_ff     <= pix_data.info.top_refl;
         left_refl_ff    <= pix_data.info.left_refl;
      end
      if (issue) begin
         rsp_grad_x_ff    <= lisg_pkg::sat_grad(gx);
         rsp_grad_y_ff    <= lisg_pkg::sat_grad(gy);
         rsp_frame_end_ff <= sel[lisg_pkg::RES_CORNER];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_grad_x    = rsp_grad_x_ff;
   assign rsp_grad_y    = rsp_grad_y_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   // the window may only move once every result of the held pixel is out
   a_take_after_flush: assert property (@(posedge clock) disable iff (reset)
      pix_take |-> (mask_ff == '0) || (issue && last_pending))
      else $error("window shifted with results pending");

   a_issue_loads: assert property (@(posedge clock) disable iff (reset)
      issue |=> rsp_valid_ff)
      else $error("issued result not presented");

   a_pending_holds: assert property (@(posedge clock) disable iff (reset)
      (mask_ff != '0) && !issue |=> $stable(mask_ff))
      else $error("pending results lost while stalled");

   a_frame_end_corner: assert property (@(posedge clock) disable iff (reset)
      issue && sel[lisg_pkg::RES_CORNER] |-> $onehot(sel) && last_pending)
      else $error("corner result not last of its pixel");

endmodule

// File: src/log_image_sobel_gradient.sv
// ----------------------------------------------------------------------------
// log_image_sobel_gradient
// Sobel x/y gradients of a log-mapped pixel stream with reflected borders.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: op 0 carries a frame pixel in raster order, op 1 writes
//    table_value into log table entry "pixel". Load the table before pixels.
//  - rsp channel: grad_x, grad_y per pixel gradient; frame_end marks the
//    result of the frame's last pixel.
//  - csr port: image_width at 0x0, image_height at 0x4 (11 bits each); write
//    only while the stream is idle.
//  - a pixel's result leaves after its lower-right neighbor arrives; pixel
//    transfer to first result passes the table/line memory read, the window
//    stage and the result register.
//  - one pixel per cycle; a pixel at a row end or in the last row may yield
//    up to four results, one per cycle from the result register while
//    rsp_ready is high, and input stalls until they are out.
//  - reset clears the position counters and pending results; the log table
//    and line memories are not cleared.
//  - when rsp_ready is low the result register holds and the stages behind
//    fill, then req_ready drops.
// ----------------------------------------------------------------------------
module log_image_sobel_gradient (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_op,
   input  logic [lisg_pkg::PIX_W-1:0] req_pixel,
   input  logic signed [lisg_pkg::IN_BITS-1:0] req_table_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [lisg_pkg::GRAD_W-1:0] rsp_grad_x,
   output logic signed [lisg_pkg::GRAD_W-1:0] rsp_grad_y,
   output logic                       rsp_frame_end,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [lisg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lisg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lisg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   lisg_pkg::dim_cfg_type  width_ff, width_in;
   lisg_pkg::dim_cfg_type  height_ff, height_in;
   logic                   csr_wr;
   logic                   csr_index;
   logic                   pix_valid, pix_take;
   lisg_pkg::pix_data_type pix_data;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr) begin
         unique case (csr_index)
            lisg_pkg::REG_IMAGE_WIDTH:  width_in  = csr_pwdata[lisg_pkg::CFG_W-1:0];
            lisg_pkg::REG_IMAGE_HEIGHT: height_in = csr_pwdata[lisg_pkg::CFG_W-1:0];
            default: ;
         endcase
      end
      unique case (csr_index)
         lisg_pkg::REG_IMAGE_WIDTH:
            csr_prdata = lisg_pkg::CSR_DATA_W'(width_ff);
         lisg_pkg::REG_IMAGE_HEIGHT:
            csr_prdata = lisg_pkg::CSR_DATA_W'(height_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lisg_pkg::CFG_W'(240);
         height_ff <= lisg_pkg::CFG_W'(180);
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   lisg_ingress u_ingress (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_op          (req_op),
      .req_pixel       (req_pixel),
      .req_table_value (req_table_value),
      .image_width     (width_ff),
      .image_height    (height_ff),
      .pix_valid       (pix_valid),
      .pix_data        (pix_data),
      .pix_take        (pix_take)
   );

   lisg_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .pix_valid     (pix_valid),
      .pix_data      (pix_data),
      .pix_take      (pix_take),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_grad_x    (rsp_grad_x),
      .rsp_grad_y    (rsp_grad_y),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// File: dv/log_image_sobel_gradient_test.sv
// ----------------------------------------------------------------------------
// log_image_sobel_gradient_test
// Loads the log table, streams pixel frames of many sizes through the block
// and checks every gradient transfer against an in-bench prediction, with
// random idling on both channels and size changes between and inside frames.
// ----------------------------------------------------------------------------
module log_image_sobel_gradient_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PIXELS = 80;
   localparam int MIN_FRAMES    = 4;
   localparam int LOADED_LOW    = 16;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_LIMIT  = 10;
   localparam int GRAD_HI       = 2 ** (lisg_pkg::GRAD_W - 1) - 1;
   localparam int GRAD_LO       = -(2 ** (lisg_pkg::GRAD_W - 1));
   localparam lisg_pkg::log_type LOG_TOP =
      lisg_pkg::log_type'(2 ** (lisg_pkg::LOG_BITS - 1) - 1);
   localparam lisg_pkg::log_type LOG_BOTTOM =
      lisg_pkg::log_type'(-(2 ** (lisg_pkg::LOG_BITS - 1)));

   typedef struct {
      lisg_pkg::grad_type gx;
      lisg_pkg::grad_type gy;
      logic               fe;
   } gradient_type;

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_valid = 1'b0;
   logic                                 req_ready;
   logic                                 req_op = lisg_pkg::OP_PIXEL;
   logic [lisg_pkg::PIX_W-1:0]           req_pixel = '0;
   logic signed [lisg_pkg::IN_BITS-1:0]  req_table_value = '0;
   logic                                 rsp_valid;
   logic                                 rsp_ready = 1'b0;
   logic signed [lisg_pkg::GRAD_W-1:0]   rsp_grad_x;
   logic signed [lisg_pkg::GRAD_W-1:0]   rsp_grad_y;
   logic                                 rsp_frame_end;
   logic                                 csr_psel = 1'b0;
   logic                                 csr_penable = 1'b0;
   logic                                 csr_pwrite = 1'b0;
   logic [lisg_pkg::CSR_ADDR_W-1:0]      csr_paddr = '0;
   logic [lisg_pkg::CSR_DATA_W-1:0]      csr_pwdata = '0;
   logic [lisg_pkg::CSR_DATA_W-1:0]      csr_prdata;
   logic                                 csr_pready;

   // predicted block state
   lisg_pkg::log_type          lut_model [lisg_pkg::TABLE_DEPTH];
   lisg_pkg::log_type          line_model [2 * lisg_pkg::MAX_WIDTH];
   lisg_pkg::log_type          window_model [3][3];   // [column][row], index 2 newest
   int unsigned                col_pos;
   int unsigned                row_pos;
   logic [lisg_pkg::CFG_W-1:0] width_cfg = 11'd240;
   logic [lisg_pkg::CFG_W-1:0] height_cfg = 11'd180;
   gradient_type               expected_grads [$];

   int gap_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int pixels_sent = 0;
   int table_writes = 0;
   int grads_checked = 0;
   int frames_seen = 0;

   log_image_sobel_gradient uut (
      .clock, .reset,
      .req_valid, .req_ready, .req_op, .req_pixel, .req_table_value,
      .rsp_valid, .rsp_ready, .rsp_grad_x, .rsp_grad_y, .rsp_frame_end,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always #1 clock = ~clock;

   function automatic void report_mismatch(string what, int want, int got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t: %s expected %0d got %0d", $realtime, what, want, got);
      end
   endfunction

   // pixels stay on the low and high table entries, which are loaded up front
   function automatic logic [lisg_pkg::PIX_W-1:0] random_pixel();
      logic [lisg_pkg::PIX_W-1:0] pix;
      pix = lisg_pkg::PIX_W'($urandom_range(LOADED_LOW - 1));
      if ($urandom_range(1) == 1) begin
         pix = lisg_pkg::PIX_W'(lisg_pkg::TABLE_DEPTH - 1) - pix;
      end
      return pix;
   endfunction

   // sobel taps over window rows t,m,b and columns l,cm,rt
   function automatic void push_gradient(int t, int m, int b, int l, int cm, int rt,
                                         logic fe);
      int           gx;
      int           gy;
      gradient_type g;
      gx = (int'(window_model[rt][t]) - int'(window_model[l][t]))
         + 2 * (int'(window_model[rt][m]) - int'(window_model[l][m]))
         + (int'(window_model[rt][b]) - int'(window_model[l][b]));
      gy = (int'(window_model[l][b]) - int'(window_model[l][t]))
         + 2 * (int'(window_model[cm][b]) - int'(window_model[cm][t]))
         + (int'(window_model[rt][b]) - int'(window_model[rt][t]));
      if (gx > GRAD_HI) gx = GRAD_HI;
      else if (gx < GRAD_LO) gx = GRAD_LO;
      if (gy > GRAD_HI) gy = GRAD_HI;
      else if (gy < GRAD_LO) gy = GRAD_LO;
      g.gx = lisg_pkg::grad_type'(gx);
      g.gy = lisg_pkg::grad_type'(gy);
      g.fe = fe;
      expected_grads.insert(expected_grads.size(), g);
   endfunction

   function automatic void predict_pixel(logic [lisg_pkg::PIX_W-1:0] pix);
      int unsigned       w;
      int unsigned       h;
      int unsigned       c;
      int unsigned       r;
      int                top;
      int                left;
      logic              last_c;
      logic              last_r;
      lisg_pkg::log_type lv;
      w = width_cfg;
      h = height_cfg;
      if (w < 2) w = 2;
      if (w > lisg_pkg::MAX_WIDTH) w = lisg_pkg::MAX_WIDTH;
      if (h < 2) h = 2;
      if (h > lisg_pkg::HEIGHT_CAP) h = lisg_pkg::HEIGHT_CAP;
      // position outside a shrunk frame starts a new one
      if (col_pos >= w || row_pos >= h) begin
         col_pos = 0;
         row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      lv = lut_model[pix];
      for (int j = 0; j < 3; j++) begin
         window_model[0][j] = window_model[1][j];
         window_model[1][j] = window_model[2][j];
      end
      window_model[2][0] = line_model[(r % 2) * lisg_pkg::MAX_WIDTH + c];
      window_model[2][1] = line_model[((r + 1) % 2) * lisg_pkg::MAX_WIDTH + c];
      window_model[2][2] = lv;
      line_model[(r % 2) * lisg_pkg::MAX_WIDTH + c] = lv;
      last_c = (c == w - 1);
      last_r = (r == h - 1);
      top = (r == 1) ? 2 : 0;
      left = (c == 1) ? 2 : 0;
      if (r > 0) begin
         if (c > 0) push_gradient(top, 1, 2, left, 1, 2, 1'b0);
         if (last_c) push_gradient(top, 1, 2, 1, 2, 1, 1'b0);
      end
      if (last_r) begin
         if (c > 0) push_gradient(1, 2, 1, left, 1, 2, 1'b0);
         if (last_c) push_gradient(1, 2, 1, 1, 2, 1, 1'b1);
      end
      if (last_c) begin
         col_pos = 0;
         row_pos = last_r ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   always @(posedge clock) begin : check_gradients
      gradient_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            grads_checked++;
            if (rsp_frame_end === 1'b1) frames_seen++;
            if (expected_grads.size() == 0) begin
               report_mismatch("gradient transfer with none pending, grad_x", 0,
                               int'(rsp_grad_x));
            end else begin
               want = expected_grads.pop_front();
               if (rsp_grad_x !== want.gx) report_mismatch("grad_x", want.gx, rsp_grad_x);
               if (rsp_grad_y !== want.gy) report_mismatch("grad_y", want.gy, rsp_grad_y);
               if (rsp_frame_end !== want.fe) begin
                  report_mismatch("frame_end", want.fe, rsp_frame_end);
               end
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(input logic op, input logic [lisg_pkg::PIX_W-1:0] pix,
                            input lisg_pkg::log_type value);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_pixel <= pix;
      req_table_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op == lisg_pkg::OP_TABLE) begin
         lut_model[pix] = value;
         table_writes++;
      end else begin
         predict_pixel(pix);
         pixels_sent++;
      end
   endtask

   task automatic send_pixel(input logic [lisg_pkg::PIX_W-1:0] pix);
      send_item(lisg_pkg::OP_PIXEL, pix, lisg_pkg::log_type'($urandom));
   endtask

   // hold the stream until every pending gradient is out and the pipe is empty
   task automatic drain_gradients();
      req_valid <= 1'b0;
      while (expected_grads.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic idx,
                             input logic [lisg_pkg::CFG_W-1:0] value,
                             output logic [lisg_pkg::CSR_DATA_W-1:0] rdata);
      logic [lisg_pkg::CSR_DATA_W-1:0] wdata;
      wdata = $urandom;
      wdata[lisg_pkg::CFG_W-1:0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= lisg_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      if (wr) begin
         if (idx == lisg_pkg::REG_IMAGE_WIDTH) width_cfg = value;
         else height_cfg = value;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_size(input logic [lisg_pkg::CFG_W-1:0] w,
                           input logic [lisg_pkg::CFG_W-1:0] h);
      logic [lisg_pkg::CSR_DATA_W-1:0] rd;
      drain_gradients();
      csr_access(1'b1, lisg_pkg::REG_IMAGE_WIDTH, w, rd);
      csr_access(1'b1, lisg_pkg::REG_IMAGE_HEIGHT, h, rd);
   endtask

   task automatic send_random_pixels(input int n, input int lut_pct, input int pause_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < lut_pct) begin
            send_item(lisg_pkg::OP_TABLE, random_pixel(), lisg_pkg::log_type'($urandom));
         end
         send_pixel(random_pixel());
         if ($urandom_range(99) < pause_pct) drain_gradients();
      end
   endtask

   // reset values first, then extremes written and read back
   task automatic test_csr_access();
      logic [lisg_pkg::CFG_W-1:0]      probe [4];
      logic [lisg_pkg::CSR_DATA_W-1:0] rd;
      logic                            idx;
      probe = '{11'd2047, 11'd0, 11'd1024, 11'd2};
      for (int v = 0; v <= 4; v++) begin
         for (int k = 0; k < 2; k++) begin
            idx = (k == 0) ? lisg_pkg::REG_IMAGE_WIDTH : lisg_pkg::REG_IMAGE_HEIGHT;
            if (v > 0) csr_access(1'b1, idx, probe[v-1], rd);
            csr_access(1'b0, idx, '0, rd);
            if (idx == lisg_pkg::REG_IMAGE_WIDTH) begin
               if (rd[lisg_pkg::CFG_W-1:0] !== width_cfg) begin
                  report_mismatch("image_width readback", width_cfg,
                                  rd[lisg_pkg::CFG_W-1:0]);
               end
            end else if (rd[lisg_pkg::CFG_W-1:0] !== height_cfg) begin
               report_mismatch("image_height readback", height_cfg,
                               rd[lisg_pkg::CFG_W-1:0]);
            end
         end
      end
   endtask

   // low and high table entries written before any pixel; darkest and brightest
   // get the extremes
   task automatic test_table_load();
      lisg_pkg::log_type low_value;
      lisg_pkg::log_type high_value;
      for (int i = 0; i < LOADED_LOW; i++) begin
         low_value = (i == 0) ? LOG_BOTTOM : lisg_pkg::log_type'($urandom);
         high_value = (i == 0) ? LOG_TOP : lisg_pkg::log_type'($urandom);
         send_item(lisg_pkg::OP_TABLE, lisg_pkg::PIX_W'(i), low_value);
         send_item(lisg_pkg::OP_TABLE, lisg_pkg::PIX_W'(lisg_pkg::TABLE_DEPTH - 1 - i),
                   high_value);
      end
   endtask

   task automatic test_directed();
      logic [lisg_pkg::PIX_W-1:0] tiny [4];
      logic [lisg_pkg::PIX_W-1:0] square [9];
      logic [lisg_pkg::PIX_W-1:0] wide [8];
      tiny = '{8'h00, 8'hFF, 8'hFF, 8'h00};
      square = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hA5, 8'h00, 8'h5A, 8'hA5, 8'hFF};
      wide = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00};
      // smallest frame: last pixel flushes all four results
      set_size(11'd2, 11'd2);
      foreach (tiny[i]) send_pixel(tiny[i]);
      // table writes inside a frame, each right before a pixel that uses it
      set_size(11'd3, 11'd3);
      foreach (square[i]) begin
         if (i == 4) send_item(lisg_pkg::OP_TABLE, 8'hA5, LOG_TOP);
         if (i == 6) send_item(lisg_pkg::OP_TABLE, 8'h5A, LOG_BOTTOM);
         send_pixel(square[i]);
      end
      set_size(11'd4, 11'd2);
      foreach (wide[i]) send_pixel(wide[i]);
   endtask

   task automatic test_size_extremes();
      // zero and one act as two
      set_size(11'd0, 11'd1);
      send_random_pixels(4, 0, 0);
      // oversize width, then shrink below the column count to restart
      set_size(11'd2047, 11'd3);
      send_random_pixels(12, 0, 0);
      set_size(11'd5, 11'd3);
      send_random_pixels(15, 0, 0);
      // oversize height, then shrink below the row count to restart
      set_size(11'd5, 11'd2047);
      send_random_pixels(20, 0, 0);
      set_size(11'd5, 11'd3);
      send_random_pixels(15, 0, 0);
      set_size(11'd1024, 11'd1024);
      send_random_pixels(10, 5, 0);
      set_size(11'd6, 11'd2);
      send_random_pixels(12, 0, 0);
   endtask

   task automatic test_random_frames();
      int gap_phase [4];
      int stall_phase [4];
      int sent;
      int frame;
      int w;
      int h;
      int n;
      gap_phase = '{0, 52, 0, 24};
      stall_phase = '{0, 0, 52, 24};
      sent = 0;
      frame = 0;
      while (sent < RANDOM_PIXELS || frame < MIN_FRAMES) begin
         w = ($urandom_range(5) == 0) ? $urandom_range(9, 24) : $urandom_range(2, 8);
         h = ($urandom_range(5) == 0) ? $urandom_range(7, 10) : $urandom_range(2, 6);
         // a cut-off frame must restart, never continue into unwritten lines
         if ((col_pos != 0 || row_pos != 0) && col_pos < w && row_pos < h) begin
            h = $urandom_range(2, row_pos);
         end
         set_size(lisg_pkg::CFG_W'(w), lisg_pkg::CFG_W'(h));
         gap_pct = gap_phase[frame % 4];
         stall_pct = stall_phase[frame % 4];
         n = w * h;
         if (h >= 3 && $urandom_range(6) == 0) n = $urandom_range(2 * w, w * h - 1);
         send_random_pixels(n, 10, 3);
         sent += n;
         frame++;
      end
   endtask

   initial begin
      for (int i = 0; i < lisg_pkg::TABLE_DEPTH; i++) lut_model[i] = '0;
      for (int i = 0; i < 2 * lisg_pkg::MAX_WIDTH; i++) line_model[i] = '0;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) window_model[i][j] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_csr_access();
      gap_pct = 52;
      test_table_load();
      gap_pct = 0;
      test_directed();
      gap_pct = 24;
      stall_pct = 24;
      test_size_extremes();
      test_random_frames();
      drain_gradients();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d pixels and %0d table loads, checked %0d gradients, %0d frame ends",
               pixels_sent, table_writes, grads_checked, frames_seen);
      $display("sizes from 2x2 to clamped 1024, restarts on shrink, idle and stall phases");
      if (mismatches == 0) begin
         $display("log_image_sobel_gradient: match");
      end else begin
         $display("log_image_sobel_gradient: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("log_image_sobel_gradient: mismatch");
      $finish;
   end

endmodule

// File: log_image_sobel_gradient.f
src/lisg_pkg.sv
src/lisg_ingress.sv
src/lisg_emit.sv
src/log_image_sobel_gradient.sv
dv/log_image_sobel_gradient_test.sv
